/* design/cvcc_pkg.sv */
// ----------------------------------------------------------------------------
// cvcc_pkg
// Shared types and constants for the CV/CC supply regulator.
// ----------------------------------------------------------------------------
package cvcc_pkg;

  localparam int AdcW   = 10;
  localparam int VoltW  = 11;
  localparam int DacW   = 12;
  localparam int ModeW  = 5;
  localparam int SumW   = 12;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 11;
  localparam int DiffW  = 14;

  localparam logic [DacW-1:0]  DacMax   = 12'hFFF;
  localparam logic [DacW-1:0]  DacMin   = 12'd400;
  localparam logic [DacW-1:0]  DacReset = 12'd800;
  localparam logic [ModeW-1:0] TripHold = 5'd20;
  localparam logic [ModeW-1:0] CcHold   = 5'd10;
  localparam logic [ModeW-1:0] ModeReset = 5'd1;
  localparam logic [VoltW-1:0] VoltReset = 11'd20;
  localparam logic [AdcW-1:0]  ScLimitReset = 10'd1000;

  localparam logic signed [DiffW-1:0] StepUp     = 14'sd1;
  localparam logic signed [DiffW-1:0] StepDown   = -14'sd1;
  localparam logic signed [DiffW-1:0] StepBig    = -14'sd20;
  localparam logic signed [DiffW-1:0] BigDropLim = -14'sd200;
  localparam logic signed [DiffW-1:0] DeadLow    = -14'sd3;
  localparam logic signed [DiffW-1:0] DeadHigh   = 14'sd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CURRENT_TARGET = 2'd0,
    REG_VOLTAGE_TARGET = 2'd1,
    REG_SC_LIMIT       = 2'd2
  } cfg_reg_t;

  // result of one control loop pass
  typedef struct packed {
    logic [DacW-1:0]  dac;
    logic [ModeW-1:0] mode;
    logic             write;
  } loop_res_t;

endpackage

/* design/cvcc_ifs.sv */
// ----------------------------------------------------------------------------
// cvcc interfaces
// Valid/ready channels for ADC items in and regulator results out.
// ----------------------------------------------------------------------------
interface cvcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [cvcc_pkg::AdcW-1:0]   adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface cvcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [cvcc_pkg::DacW-1:0]   dac_value;
  logic                        dac_write;
  logic                        current_limit_active;
  logic                        short_circuit;
  logic [cvcc_pkg::VoltW-1:0]  voltage_reading;
  logic [cvcc_pkg::AdcW-1:0]   current_reading;

  modport source (output valid, output dac_value, output dac_write,
                  output current_limit_active, output short_circuit,
                  output voltage_reading, output current_reading, input ready);
  modport sink   (input valid, input dac_value, input dac_write,
                  input current_limit_active, input short_circuit,
                  input voltage_reading, input current_reading, output ready);
endinterface

/* design/cvcc_loop.sv */
// ----------------------------------------------------------------------------
// cvcc_loop
// One pass of the CV/CC control loop: mode hold, deadband, step caps, clamp.
// ----------------------------------------------------------------------------
module cvcc_loop (
  input  logic [cvcc_pkg::AdcW-1:0]  current_target,
  input  logic [cvcc_pkg::VoltW-1:0] voltage_target,
  input  logic [cvcc_pkg::AdcW-1:0]  current_measured,
  input  logic [cvcc_pkg::VoltW-1:0] voltage_filtered,
  input  logic [cvcc_pkg::DacW-1:0]  dac_setting,
  input  logic [cvcc_pkg::ModeW-1:0] mode_counter,
  output cvcc_pkg::loop_res_t        res
);
  import cvcc_pkg::*;

  logic signed [DiffW-1:0] d_cc;
  logic signed [DiffW-1:0] d_cv;
  logic signed [DiffW-1:0] d;
  logic signed [DiffW-1:0] step;
  logic signed [DiffW-1:0] sum;
  logic [ModeW-1:0]        mode;

  assign d_cc = $signed({{(DiffW-AdcW){1'b0}}, current_target})
              - $signed({{(DiffW-AdcW){1'b0}}, current_measured});
  assign d_cv = StepUp
              + $signed({{(DiffW-VoltW){1'b0}}, voltage_target})
              - $signed({{(DiffW-VoltW){1'b0}}, voltage_filtered});

  always_comb begin
    d    = d_cc;
    mode = mode_counter;
    if (d_cc < 0) begin
      // current control
      if (d_cc == StepDown) d = '0;
      mode = CcHold;
      if (voltage_filtered > voltage_target) begin
        d    = StepBig;
        mode = '0;
      end
    end else begin
      d = d_cv;
      if (mode_counter != '0) begin
        mode = mode_counter - 1'b1;
        if (d_cv > 0) d = '0;
      end
    end

    if (d > StepUp) step = StepUp;
    else if (d < BigDropLim) step = StepBig;
    else if (d < StepDown) step = StepDown;
    else step = d;

    sum = $signed({{(DiffW-DacW){1'b0}}, dac_setting}) + step;

    res.mode  = mode;
    res.write = !(d > DeadLow && d < DeadHigh);
    if (!res.write) res.dac = dac_setting;
    else if (sum > $signed({{(DiffW-DacW){1'b0}}, DacMax})) res.dac = DacMax;
    else if (sum < $signed({{(DiffW-DacW){1'b0}}, DacMin})) res.dac = DacMin;
    else res.dac = sum[DacW-1:0];
  end

endmodule

/* design/cv_cc_supply_dac_regulator.sv */
// ----------------------------------------------------------------------------
// cv_cc_supply_dac_regulator
// CV/CC supply regulator: alternating ADC samples in, DAC setting out.
// ----------------------------------------------------------------------------
// Takes one ADC item per clock while the output is not stalled and returns
// one result per item. An accepted item is loaded into the input register,
// then into the result register; both hold while the output stalls. The items
// alternate voltage/current starting with voltage after reset. The regulator
// state is updated as each item leaves the input register, so every item sees
// the state left by the one before it with no stall. Configuration writes take
// effect immediately and must only be issued while no item is in flight.
module cv_cc_supply_dac_regulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cvcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cvcc_pkg::CfgDataW-1:0] cfg_data,
  cvcc_in_if.sink                       in,
  cvcc_out_if.source                    out
);
  import cvcc_pkg::*;

  logic [AdcW-1:0]  current_target;
  logic [VoltW-1:0] voltage_target;
  logic [AdcW-1:0]  short_circuit_limit;

  logic             s1_valid;
  logic [AdcW-1:0]  s1_sample;
  logic             advance;

  logic             channel_bit;
  logic [1:0]       ring_position;
  logic [AdcW-1:0]  voltage_ring [4];
  logic [VoltW-1:0] voltage_filtered;
  logic [AdcW-1:0]  current_measured;
  logic [DacW-1:0]  dac_setting;
  logic [ModeW-1:0] mode_counter;

  logic [AdcW-1:0]  ring_next [4];
  logic [SumW-1:0]  ring_sum;
  logic [SumW-1:0]  avg_sum;
  logic [VoltW-1:0] voltage_filtered_next;
  logic             is_voltage;
  logic             trip;
  loop_res_t        loop_res;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      current_target      <= '0;
      voltage_target      <= '0;
      short_circuit_limit <= ScLimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURRENT_TARGET: current_target      <= cfg_data[AdcW-1:0];
        REG_VOLTAGE_TARGET: voltage_target      <= cfg_data[VoltW-1:0];
        REG_SC_LIMIT:       short_circuit_limit <= cfg_data[AdcW-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out.valid || out.ready;
  assign in.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.ready) begin
      s1_valid <= in.valid;
    end
    if (in.ready) s1_sample <= in.adc_sample;
  end

  // voltage filter
  assign is_voltage = !channel_bit;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ring_next[i] = (ring_position == 2'(i)) ? s1_sample : voltage_ring[i];
    end
    ring_sum = SumW'(ring_next[0]) + SumW'(ring_next[1])
             + SumW'(ring_next[2]) + SumW'(ring_next[3]);
    avg_sum  = {1'b0, ring_sum[SumW-1:1]} + SumW'(voltage_filtered);
    voltage_filtered_next = avg_sum[VoltW:1];
  end

  assign trip = !is_voltage && (s1_sample > short_circuit_limit);

  cvcc_loop u_loop (
    .current_target   (current_target),
    .voltage_target   (voltage_target),
    .current_measured (current_measured),
    .voltage_filtered (voltage_filtered_next),
    .dac_setting      (dac_setting),
    .mode_counter     (mode_counter),
    .res              (loop_res)
  );

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid        <= 1'b0;
      channel_bit      <= 1'b0;
      ring_position    <= '0;
      for (int i = 0; i < 4; i++) voltage_ring[i] <= '0;
      voltage_filtered <= VoltReset;
      current_measured <= '0;
      dac_setting      <= DacReset;
      mode_counter     <= ModeReset;
    end else if (advance) begin
      out.valid <= s1_valid;
      if (s1_valid) begin
        channel_bit <= !channel_bit;
        if (is_voltage) begin
          for (int i = 0; i < 4; i++) voltage_ring[i] <= ring_next[i];
          ring_position    <= ring_position + 2'd1;
          voltage_filtered <= voltage_filtered_next;
          dac_setting      <= loop_res.dac;
          mode_counter     <= loop_res.mode;
        end else begin
          current_measured <= s1_sample;
          if (trip) begin
            dac_setting  <= DacMin;
            mode_counter <= TripHold;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (is_voltage) begin
        out.dac_value            <= loop_res.dac;
        out.dac_write            <= loop_res.write;
        out.current_limit_active <= (loop_res.mode != '0);
        out.short_circuit        <= 1'b0;
        out.voltage_reading      <= voltage_filtered_next;
        out.current_reading      <= current_measured;
      end else begin
        out.dac_value            <= trip ? DacMin : dac_setting;
        out.dac_write            <= trip;
        out.current_limit_active <= trip || (mode_counter != '0);
        out.short_circuit        <= trip;
        out.voltage_reading      <= voltage_filtered;
        out.current_reading      <= s1_sample;
      end
    end
  end

  a_dac_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.dac_value >= DacMin)
    else $error("dac_value below minimum");

  a_trip_result: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.short_circuit |->
      out.dac_write && out.current_limit_active && out.dac_value == DacMin)
    else $error("short-circuit result inconsistent");

  a_mode_bound: assert property (@(posedge clk) disable iff (rst)
    mode_counter <= TripHold)
    else $error("mode counter out of range");

  a_channel_toggle: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid |=> channel_bit != $past(channel_bit))
    else $error("channel bit did not toggle on item");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_sample))
    else $error("stalled input item lost");

endmodule
